FILE: hdl/afc_pkg.sv
// Package for the 2-D affine transform composer: widths, command codes,
// step kinds and the round/saturate helpers. Depends on nothing.
`default_nettype none

package afc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int MAT_DIM   = 3;
    localparam int MAT_N     = MAT_DIM * MAT_DIM;
    localparam int MAT_IW    = $clog2(MAT_N);
    localparam int IN_BITS   = 32;
    localparam int OUT_BITS  = 32;

    // Multiplier operand: a matrix entry or an exact entry of the step matrix
    // (a negated input needs one extra bit).
    localparam int OP_W   = ((WORD_BITS > IN_BITS) ? WORD_BITS : IN_BITS) + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = PROD_W + 2;

    // Line direction datapath.
    localparam int DIF_W   = IN_BITS + 1;
    localparam int NORM_HI = 30;
    localparam int NORM_LO = 29;
    localparam int SQ_W    = 64;
    localparam int LEN_W   = 32;
    localparam int SQRT_N  = SQ_W / 2;
    localparam int NUM_W   = NORM_HI + FRAC_BITS + 1;
    localparam int CNT_W   = 6;

    typedef enum logic [2:0] {
        CMD_IDENT = 3'd0,
        CMD_TRANS = 3'd1,
        CMD_ROT   = 3'd2,
        CMD_SCALE = 3'd3,
        CMD_PIVOT = 3'd4,
        CMD_SYMM  = 3'd5,
        CMD_LINE  = 3'd6,
        CMD_POINT = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        K_TRANS = 2'd0,
        K_ROT   = 2'd1,
        K_SCALE = 2'd2
    } t_kind;

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] W_MAX = (ACC_W'(1) << (WORD_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] W_MIN = -W_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] O_MAX = (ACC_W'(1) << (OUT_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] O_MIN = -O_MAX - ACC_W'(1);

    // Round half up and drop the fraction bits.
    function automatic logic signed [ACC_W-1:0] round_acc(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        begin
            t = acc + HALF_LSB;
            return t >>> FRAC_BITS;
        end
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] r;
        begin
            r = round_acc(acc);
            if (r > W_MAX) r = W_MAX;
            else if (r < W_MIN) r = W_MIN;
            return r[WORD_BITS-1:0];
        end
    endfunction

    function automatic logic signed [OUT_BITS-1:0] sat_out(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] r;
        begin
            r = round_acc(acc);
            if (r > O_MAX) r = O_MAX;
            else if (r < O_MIN) r = O_MIN;
            return r[OUT_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/affine_transform_2d_composer_top.sv
// Top level of the 2-D affine transform composer: matrix store, shared
// multiply-accumulate, square root and divider sequencer. Uses afc_pkg.
// Sequence: a point runs nine multiplies, a drain and a commit; translate,
//   rotate and scale run one matrix step; pivot rotate and point symmetry three;
//   line reflect normalizes, squares, takes a root, divides twice, then five steps.
// Requests are taken one at a time; the input stalls from accept until the
//   sequencer is back in idle. The single 33x33 multiplier sets the pace.
// Reset (synchronous, active low): matrix to identity, sequencer idle, no result.
`default_nettype none

module affine_transform_2d_composer_top
    import afc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [2:0]                  i_cmd,
    input  wire logic signed [IN_BITS-1:0]   i_arg_a,
    input  wire logic signed [IN_BITS-1:0]   i_arg_b,
    input  wire logic signed [IN_BITS-1:0]   i_arg_c,
    input  wire logic signed [IN_BITS-1:0]   i_arg_d,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [OUT_BITS-1:0]       o_out_x,
    output logic signed [OUT_BITS-1:0]       o_out_y,
    output logic signed [OUT_BITS-1:0]       o_out_w
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_NORM   = 10'b00_0000_0010,
        S_SQA    = 10'b00_0000_0100,
        S_SQB    = 10'b00_0000_1000,
        S_SQC    = 10'b00_0001_0000,
        S_SQRT   = 10'b00_0010_0000,
        S_DIV    = 10'b00_0100_0000,
        S_MAC    = 10'b00_1000_0000,
        S_DRAIN  = 10'b01_0000_0000,
        S_COMMIT = 10'b10_0000_0000
    } t_state;

    localparam logic signed [OP_W-1:0] ONE_Q = OP_W'(1) << FRAC_BITS;

    t_state r_state;

    // Request registers.
    t_cmd                    r_cmd;
    logic signed [OP_W-1:0]  r_a, r_b, r_c, r_d;
    logic signed [OP_W-1:0]  r_cs, r_sn;
    logic [2:0]              r_sidx;

    // Matrix and its next value.
    logic signed [WORD_BITS-1:0] r_mat [MAT_N];
    logic signed [WORD_BITS-1:0] r_new [MAT_N];
    logic signed [OUT_BITS-1:0]  r_pnt [MAT_DIM];

    // Loop counters: row i, column j, inner index k.
    logic [1:0] r_i, r_j, r_k;

    // Multiply and accumulate pipeline.
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv, r_pfirst, r_plast;
    logic [MAT_IW-1:0]        r_pdst;
    logic signed [ACC_W-1:0]  r_acc;

    // Line direction.
    logic [DIF_W-1:0]  r_ax, r_ay;
    logic              r_dxneg, r_dyneg;
    logic [SQ_W-1:0]   r_sq, r_v, r_res, r_bit;
    logic [LEN_W-1:0]  r_len, r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_divs;

    logic              r_out_valid;
    logic signed [OUT_BITS-1:0] r_ox, r_oy, r_ow;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic in_acc, out_free, is_point;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_point   = (r_cmd == CMD_POINT);

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_w     = r_ow;

    // Sign-extended request fields and the line difference.
    logic signed [OP_W-1:0]  in_a, in_b, in_c, in_d;
    logic signed [DIF_W-1:0] dx, dy;
    assign in_a = OP_W'(i_arg_a);
    assign in_b = OP_W'(i_arg_b);
    assign in_c = OP_W'(i_arg_c);
    assign in_d = OP_W'(i_arg_d);
    assign dx = DIF_W'(i_arg_c) - DIF_W'(i_arg_a);
    assign dy = DIF_W'(i_arg_d) - DIF_W'(i_arg_b);

    // ---------------------------------------------------------------
    // Step program: each command is a short list of elementary matrices
    // ---------------------------------------------------------------
    t_kind                  st_kind;
    logic signed [OP_W-1:0] st_p, st_q;
    logic                   last_step;

    always_comb begin
        st_kind   = K_TRANS;
        st_p      = r_a;
        st_q      = r_b;
        last_step = 1'b1;
        case (r_cmd)
            CMD_ROT: begin
                st_kind = K_ROT;
            end
            CMD_SCALE: begin
                st_kind = K_SCALE;
            end
            CMD_PIVOT: begin
                last_step = (r_sidx == 3'd2);
                case (r_sidx)
                    3'd0: begin
                        st_kind = K_TRANS;
                    end
                    3'd1: begin
                        st_kind = K_ROT;
                        st_p    = r_c;
                        st_q    = r_d;
                    end
                    default: begin
                        st_p = -r_a;
                        st_q = -r_b;
                    end
                endcase
            end
            CMD_SYMM: begin
                last_step = (r_sidx == 3'd2);
                case (r_sidx)
                    3'd0: begin
                        st_kind = K_TRANS;
                    end
                    3'd1: begin
                        st_kind = K_SCALE;
                        st_p    = -ONE_Q;
                        st_q    = -ONE_Q;
                    end
                    default: begin
                        st_p = -r_a;
                        st_q = -r_b;
                    end
                endcase
            end
            CMD_LINE: begin
                last_step = (r_sidx == 3'd4);
                case (r_sidx)
                    3'd0: begin
                        st_kind = K_TRANS;
                    end
                    3'd1: begin
                        st_kind = K_ROT;
                        st_p    = r_cs;
                        st_q    = r_sn;
                    end
                    3'd2: begin
                        st_kind = K_SCALE;
                        st_p    = ONE_Q;
                        st_q    = -ONE_Q;
                    end
                    3'd3: begin
                        st_kind = K_ROT;
                        st_p    = r_cs;
                        st_q    = -r_sn;
                    end
                    default: begin
                        st_p = -r_a;
                        st_q = -r_b;
                    end
                endcase
            end
            default: begin
                st_kind = K_TRANS;
            end
        endcase
    end

    // Entry (k, j) of the step matrix; the bottom row is always (0, 0, 1).
    logic signed [OP_W-1:0] e_val;
    always_comb begin
        e_val = '0;
        if (r_k == 2'd2) begin
            e_val = (r_j == 2'd2) ? ONE_Q : '0;
        end else begin
            case (st_kind)
                K_TRANS: begin
                    if (r_k == r_j) e_val = ONE_Q;
                    else if (r_j == 2'd2) e_val = (r_k == 2'd0) ? st_p : st_q;
                end
                K_ROT: begin
                    if (r_j == 2'd2) e_val = '0;
                    else if (r_k == r_j) e_val = st_p;
                    else if (r_k == 2'd0) e_val = -st_q;
                    else e_val = st_q;
                end
                K_SCALE: begin
                    if (r_k == r_j) e_val = (r_k == 2'd0) ? st_p : st_q;
                end
                default: begin
                    e_val = '0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Shared multiplier operand select
    // ---------------------------------------------------------------
    logic [MAT_IW-1:0]      mat_idx, dst_idx;
    logic signed [OP_W-1:0] mul_a, mul_b, pnt_op;

    assign mat_idx = MAT_IW'({r_i, 1'b0}) + MAT_IW'(r_i) + MAT_IW'(r_k);
    assign dst_idx = is_point ? MAT_IW'(r_i)
                              : MAT_IW'({r_i, 1'b0}) + MAT_IW'(r_i) + MAT_IW'(r_j);
    assign pnt_op  = (r_k == 2'd0) ? r_a : ((r_k == 2'd1) ? r_b : r_c);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MAC: begin
                mul_a = OP_W'(r_mat[mat_idx]);
                mul_b = is_point ? pnt_op : e_val;
            end
            S_SQA: begin
                mul_a = OP_W'(r_ax);
                mul_b = OP_W'(r_ax);
            end
            S_SQB: begin
                mul_a = OP_W'(r_ay);
                mul_b = OP_W'(r_ay);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Accumulate stage: restart on the first product of an entry, write on its last.
    logic signed [ACC_W-1:0] acc_sum;
    assign acc_sum = (r_pfirst ? '0 : r_acc) + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_acc <= acc_sum;
            if (r_plast) begin
                r_new[r_pdst] <= sat_word(acc_sum);
                if (r_pdst < MAT_IW'(MAT_DIM)) begin
                    r_pnt[r_pdst[1:0]] <= sat_out(acc_sum);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfirst <= (r_k == 2'd0);
        r_plast  <= (r_k == 2'd2);
        r_pdst   <= dst_idx;
    end

    // ---------------------------------------------------------------
    // Square root and divider steps
    // ---------------------------------------------------------------
    logic [DIF_W-1:0] mx;
    assign mx = (r_ax > r_ay) ? r_ax : r_ay;

    logic [SQ_W-1:0] sq_t, res_nx, v_nx;
    logic            sq_ge;
    assign sq_t   = r_res + r_bit;
    assign sq_ge  = (r_v >= sq_t);
    assign v_nx   = sq_ge ? (r_v - sq_t) : r_v;
    assign res_nx = sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    logic [LEN_W:0]   dv_t;
    logic             dv_ge;
    logic [LEN_W-1:0] rem_nx;
    logic [NUM_W-1:0] num_nx;
    logic signed [OP_W-1:0] quo_mag;
    assign dv_t    = {r_rem, r_num[NUM_W-1]};
    assign dv_ge   = (dv_t >= {1'b0, r_len});
    assign rem_nx  = dv_ge ? LEN_W'(dv_t - {1'b0, r_len}) : LEN_W'(dv_t);
    assign num_nx  = {r_num[NUM_W-2:0], dv_ge};
    assign quo_mag = OP_W'(num_nx);

    // Numerator of the direction divide: |d| in Q form plus half the length.
    function automatic logic [NUM_W-1:0] div_num(input logic [DIF_W-1:0] mag,
                                                 input logic [LEN_W-1:0] len);
        begin
            return (NUM_W'(mag) << FRAC_BITS) + NUM_W'(len >> 1);
        end
    endfunction

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic mac_end;
    assign mac_end = (r_k == 2'd2) && (r_i == 2'd2) && (is_point || (r_j == 2'd2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
            for (int n = 0; n < MAT_N; n++) begin
                r_mat[n] <= (n % (MAT_DIM + 1) == 0) ? WORD_BITS'(1) << FRAC_BITS
                                                      : '0;
            end
        end else begin
            // Drop the result once the downstream side takes it, unless a new
            // point is loaded in the same cycle.
            if (r_out_valid && !i_out_stall && !(r_state == S_COMMIT && is_point))
                r_out_valid <= 1'b0;
            r_pv <= (r_state == S_MAC);

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= t_cmd'(i_cmd);
                        r_a     <= in_a;
                        r_b     <= in_b;
                        r_c     <= in_c;
                        r_d     <= in_d;
                        r_sidx  <= '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_ax    <= dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
                        r_ay    <= dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);
                        r_dxneg <= dx[DIF_W-1];
                        r_dyneg <= dy[DIF_W-1];
                        case (t_cmd'(i_cmd))
                            CMD_IDENT: begin
                                for (int n = 0; n < MAT_N; n++) begin
                                    r_mat[n] <= (n % (MAT_DIM + 1) == 0)
                                                ? WORD_BITS'(1) << FRAC_BITS : '0;
                                end
                            end
                            CMD_LINE: begin
                                // Zero-length line: leave the matrix alone.
                                if (dx != '0 || dy != '0) r_state <= S_NORM;
                            end
                            default: begin
                                r_state <= S_MAC;
                            end
                        endcase
                    end
                end
                S_NORM: begin
                    // Bring the larger magnitude into [2^29, 2^30), one bit a cycle.
                    if (mx >= (DIF_W'(1) << NORM_HI)) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else if (mx < (DIF_W'(1) << NORM_LO)) begin
                        r_ax <= r_ax << 1;
                        r_ay <= r_ay << 1;
                    end else begin
                        r_state <= S_SQA;
                    end
                end
                S_SQA: begin
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_sq    <= SQ_W'(r_prod);
                    r_state <= S_SQC;
                end
                S_SQC: begin
                    r_v     <= r_sq + SQ_W'(r_prod);
                    r_res   <= '0;
                    r_bit   <= SQ_W'(1) << (SQ_W - 2);
                    r_cnt   <= CNT_W'(SQRT_N - 1);
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_v   <= v_nx;
                    r_res <= res_nx;
                    r_bit <= r_bit >> 2;
                    if (r_cnt == '0) begin
                        r_len   <= LEN_W'(res_nx);
                        r_num   <= div_num(r_ax, LEN_W'(res_nx));
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(NUM_W - 1);
                        r_divs  <= 1'b0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        if (!r_divs) begin
                            r_cs   <= r_dxneg ? -quo_mag : quo_mag;
                            r_num  <= div_num(r_ay, r_len);
                            r_rem  <= '0;
                            r_cnt  <= CNT_W'(NUM_W - 1);
                            r_divs <= 1'b1;
                        end else begin
                            r_sn    <= r_dyneg ? -quo_mag : quo_mag;
                            r_state <= S_MAC;
                        end
                    end else begin
                        r_rem <= rem_nx;
                        r_num <= num_nx;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_MAC: begin
                    // Advance k, then j (held at zero for a point), then i; one product per cycle.
                    if (r_k != 2'd2) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_k <= '0;
                        if (!is_point && r_j != 2'd2) begin
                            r_j <= r_j + 1'b1;
                        end else begin
                            r_j <= '0;
                            r_i <= r_i + 1'b1;
                        end
                    end
                    if (mac_end) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_i <= '0;
                    r_j <= '0;
                    r_k <= '0;
                    if (is_point) begin
                        // Hold until the output register is free.
                        if (out_free) begin
                            r_ox        <= r_pnt[0];
                            r_oy        <= r_pnt[1];
                            r_ow        <= r_pnt[2];
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        for (int n = 0; n < MAT_N; n++) r_mat[n] <= r_new[n];
                        if (last_step) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sidx  <= r_sidx + 1'b1;
                            r_state <= S_MAC;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_out_from_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_COMMIT && r_cmd == CMD_POINT))
        else $error("result raised outside a point commit");

    a_mat_hold_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_SQRT) |=> $stable(r_mat[0]) && $stable(r_mat[4]))
        else $error("matrix changed during direction computation");

    a_drain_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_pv && r_plast))
        else $error("drain cycle without final accumulate write");

endmodule

`default_nettype wire

FILE: dv/tb_affine_transform_2d_composer_top.sv
// Self-checking testbench for the 2-D affine transform composer top level.
// Holds its own matrix predictor and a small scoreboard class. Uses afc_pkg.
`default_nettype none

module tb_affine_transform_2d_composer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import afc_pkg::*;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word w;
    } t_point;

    // Scoreboard: keeps the running matrix and the queue of expected points.
    class point_scoreboard;
        longint mat[9];
        t_point pending[$];
        int     errors;
        int     checked;

        function new();
            errors  = 0;
            checked = 0;
            set_identity();
        endfunction

        function void set_identity();
            for (int i = 0; i < 9; i++) mat[i] = (i % 4 == 0) ? 64'sd65536 : 64'sd0;
        endfunction

        // Round half up, shift out the fraction, saturate to 32 bits.
        function longint round_sat(logic signed [127:0] acc);
            logic signed [127:0] r;
            r = (acc + 128'sd32768) >>> 16;
            if (r > 128'sd2147483647) return 64'sd2147483647;
            if (r < -128'sd2147483648) return -64'sd2147483648;
            return longint'(r);
        endfunction

        function void compose(longint e00, longint e01, longint e02,
                              longint e10, longint e11, longint e12);
            longint e[9];
            longint r[9];
            logic signed [127:0] acc;
            e = '{e00, e01, e02, e10, e11, e12, 0, 0, 65536};
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                        acc += 128'(mat[i*3+k]) * 128'(e[k*3+j]);
                    r[i*3+j] = round_sat(acc);
                end
            mat = r;
        endfunction

        function void shift_by(longint dx, longint dy);
            compose(65536, 0, dx, 0, 65536, dy);
        endfunction

        function longint floor_sqrt(longint unsigned v);
            longint unsigned res, bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   -= res + bitv;
                    res  = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function void reflect_line(longint sx, longint sy, longint ex, longint ey);
            longint dx, dy, c, s;
            longint unsigned ax, ay, mx, len, cm, sm;
            dx = ex - sx;
            dy = ey - sy;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (ax == 0 && ay == 0) return;
            mx = (ax > ay) ? ax : ay;
            while (mx >= (64'd1 << 30)) begin ax >>= 1; ay >>= 1; mx >>= 1; end
            while (mx < (64'd1 << 29)) begin ax <<= 1; ay <<= 1; mx <<= 1; end
            len = floor_sqrt(ax*ax + ay*ay);
            cm  = ((ax << 16) + len/2) / len;
            sm  = ((ay << 16) + len/2) / len;
            c   = (dx < 0) ? -longint'(cm) : longint'(cm);
            s   = (dy < 0) ? -longint'(sm) : longint'(sm);
            shift_by(sx, sy);
            compose(c, -s, 0, s, c, 0);
            compose(65536, 0, 0, 0, -65536, 0);
            compose(c, s, 0, -s, c, 0);
            shift_by(-sx, -sy);
        endfunction

        // Note one accepted request and update the matrix or queue a point.
        function void note_request(t_cmd cmd, t_word a, t_word b, t_word c, t_word d);
            longint la, lb, lc, ld;
            logic signed [127:0] acc;
            longint p[3];
            t_point pt;
            la = a; lb = b; lc = c; ld = d;
            case (cmd)
                CMD_IDENT: set_identity();
                CMD_TRANS: shift_by(la, lb);
                CMD_ROT:   compose(la, -lb, 0, lb, la, 0);
                CMD_SCALE: compose(la, 0, 0, 0, lb, 0);
                CMD_PIVOT: begin
                    shift_by(la, lb);
                    compose(lc, -ld, 0, ld, lc, 0);
                    shift_by(-la, -lb);
                end
                CMD_SYMM: begin
                    shift_by(la, lb);
                    compose(-65536, 0, 0, 0, -65536, 0);
                    shift_by(-la, -lb);
                end
                CMD_LINE: reflect_line(la, lb, lc, ld);
                default: begin
                    p = '{la, lb, lc};
                    for (int i = 0; i < 3; i++) begin
                        acc = 0;
                        for (int k = 0; k < 3; k++)
                            acc += 128'(mat[i*3+k]) * 128'(p[k]);
                        if (i == 0) pt.x = t_word'(round_sat(acc));
                        else if (i == 1) pt.y = t_word'(round_sat(acc));
                        else pt.w = t_word'(round_sat(acc));
                    end
                    pending.push_back(pt);
                end
            endcase
        endfunction

        function void check_point(t_word x, t_word y, t_word w);
            t_point e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected point x=%0d y=%0d w=%0d", $time, x, y, w);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.x !== x) begin
                $display("%0t: out_x expected %0d actual %0d", $time, e.x, x);
                errors++;
            end
            if (e.y !== y) begin
                $display("%0t: out_y expected %0d actual %0d", $time, e.y, y);
                errors++;
            end
            if (e.w !== w) begin
                $display("%0t: out_w expected %0d actual %0d", $time, e.w, w);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 830;
    localparam int LONG_HOLD  = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_cmd;
    t_word       i_arg_a, i_arg_b, i_arg_c, i_arg_d;
    logic        o_out_valid;
    logic        i_out_stall;
    t_word       o_out_x, o_out_y, o_out_w;

    point_scoreboard sb;
    bit  quiet_phase;     // no idling in the last part of the run
    bit  hold_request;    // ask the receiver for one long hold-off
    int  idle_cycles;
    int  n_requests;

    affine_transform_2d_composer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_arg_a    (i_arg_a),
        .i_arg_b    (i_arg_b),
        .i_arg_c    (i_arg_c),
        .i_arg_d    (i_arg_d),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_w    (o_out_w)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offer one request at the falling edge and hold it until accepted.
    // Valid stays high into the next request unless an idle gap comes first.
    task automatic send_request(t_cmd cmd, t_word a, t_word b, t_word c, t_word d);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_arg_a    <= a;
        i_arg_b    <= b;
        i_arg_c    <= c;
        i_arg_d    <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(cmd, a, b, c, d);
        n_requests++;
        @(negedge i_clk);
    endtask

    // Pick a value that leans toward the interesting ranges of Q16.16.
    function automatic t_word pick_value();
        case ($urandom_range(0, 7))
            0: return t_word'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            2: return t_word'(65536);
            3: return t_word'(-65536);
            4: return t_word'(0);
            default: return t_word'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
        endcase
    endfunction

    // Cosine/sine pair near the unit circle, with some noise.
    task automatic pick_angle(output t_word c, output t_word s);
        real ang;
        ang = $urandom_range(0, 6283) / 1000.0;
        c = t_word'($rtoi($cos(ang) * 65536.0)) + t_word'($urandom_range(0, 4)) - 2;
        s = t_word'($rtoi($sin(ang) * 65536.0)) + t_word'($urandom_range(0, 4)) - 2;
    endtask

    task automatic random_request();
        t_word a, b, c, d;
        t_cmd  cmd;
        int    pick;
        a = pick_value();
        b = pick_value();
        c = pick_value();
        d = pick_value();
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            cmd = CMD_POINT;
            if ($urandom_range(0, 3) != 0) c = t_word'(65536);
        end else if (pick < 50) cmd = CMD_TRANS;
        else if (pick < 60) begin
            cmd = CMD_ROT;
            if ($urandom_range(0, 3) != 0) pick_angle(a, b);
        end else if (pick < 67) begin
            cmd = CMD_SCALE;
            if ($urandom_range(0, 3) != 0) begin
                a = t_word'($urandom_range(16384, 131072));
                b = t_word'($urandom_range(16384, 131072));
            end
        end else if (pick < 74) begin
            cmd = CMD_PIVOT;
            if ($urandom_range(0, 3) != 0) pick_angle(c, d);
        end else if (pick < 80) cmd = CMD_SYMM;
        else if (pick < 92) begin
            cmd = CMD_LINE;
            if ($urandom_range(0, 7) == 0) begin
                c = a;
                d = b;
            end
        end else cmd = CMD_IDENT;
        send_request(cmd, a, b, c, d);
    endtask

    // Receiver: random stall bursts, one long hold-off, none at the end.
    initial begin
        int burst;
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall  <= 1'b0;
                hold_request  = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 6);
                i_out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Check each accepted point at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_point(o_out_x, o_out_y, o_out_w);
    end

    // Watchdog: count cycles in which nothing is accepted.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb_affine_transform_2d_composer_top failed");
            $finish;
        end
    end

    initial begin
        t_word c, s;
        sb            = new();
        quiet_phase   = 1'b0;
        hold_request  = 1'b0;
        idle_cycles   = 0;
        n_requests    = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd      <= CMD_IDENT;
        i_arg_a    <= '0;
        i_arg_b    <= '0;
        i_arg_c    <= '0;
        i_arg_d    <= '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: identity, every command, field extremes, zero-length line.
        send_request(CMD_POINT, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 32'sh0);
        send_request(CMD_TRANS, 32'sh00030000, -32'sh00020000, 0, 0);
        send_request(CMD_POINT, 32'sh00010000, 32'sh00010000, 32'sh00010000, 0);
        send_request(CMD_ROT, 0, 32'sh00010000, 0, 0);
        send_request(CMD_POINT, 32'sh00020000, 32'sh00050000, 32'sh00010000, 0);
        send_request(CMD_SCALE, 32'sh00020000, 32'sh00008000, 0, 0);
        send_request(CMD_POINT, -32'sh00010000, 32'sh00040000, 32'sh00010000, 0);
        pick_angle(c, s);
        send_request(CMD_PIVOT, 32'sh00100000, -32'sh00080000, c, s);
        send_request(CMD_SYMM, 32'sh00011000, 32'sh00022000, 0, 0);
        send_request(CMD_POINT, 32'sh00007000, 32'sh00009000, 32'sh00010000, 0);
        send_request(CMD_LINE, 0, 0, 32'sh00010000, 32'sh00010000);
        send_request(CMD_LINE, 32'sh00050000, 32'sh00050000, 32'sh00050000, 32'sh00050000);
        send_request(CMD_LINE, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
        send_request(CMD_POINT, 32'sh00030000, 32'sh00010000, 32'sh00010000, 0);
        send_request(CMD_SCALE, 32'sh7FFFFFFF, 32'sh80000000, 0, 0);
        send_request(CMD_TRANS, 32'sh7FFFFFFF, 32'sh80000000, 0, 0);
        send_request(CMD_POINT, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'shFFFFFFFF);
        send_request(CMD_ROT, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
        send_request(CMD_POINT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        send_request(CMD_IDENT, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF);
        send_request(CMD_POINT, 32'sh12345678, -32'sh0ABCDEF0, 32'sh00010000, 0);

        // Random part; fill the block during one long receiver hold-off.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) hold_request = 1'b1;
            if (n == N_RANDOM - 150) quiet_phase = 1'b1;
            random_request();
        end
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d requests over all eight commands, checked %0d points.",
                 n_requests, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_affine_transform_2d_composer_top passed");
        end else begin
            $display("tb_affine_transform_2d_composer_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
